// ===== sv/tvfe_pkg.sv =====
// Package: shared types, constants and the period table of the voice effect engine.
package tvfe_pkg;

    localparam int          VOICES_DEF = 4;
    localparam logic [9:0]  PER_MIN    = 10'd135;
    localparam logic [9:0]  PER_MAX    = 10'd1019;
    localparam logic [5:0]  TAB_LAST   = 6'd50;
    localparam logic [7:0]  LEVEL_MAX  = 8'd64;
    localparam logic [15:0] AM_WORDS   = 16'h0020;
    localparam logic [7:0]  BYTE_STOP  = 8'd255;
    localparam logic [3:0]  SPEED_RST  = 4'd6;
    localparam logic        CMD_TICK   = 1'b0;
    localparam logic        CMD_ROW    = 1'b1;

    // Decoded item handed from the front to the back
    typedef struct packed {
        logic        cmd;
        logic [1:0]  voice;
        logic        in_range;
        logic        has_note;
        logic [5:0]  note_idx;
        logic [9:0]  note_per;
        logic        porta_tgt;
        logic        vol_preset;
        logic [3:0]  speed;
        logic [7:0]  arp;
        logic [7:0]  vib;
        logic [7:0]  vol;
        logic [7:0]  porta;
        logic        inst_present;
        logic [1:0]  inst_flags;
        logic [15:0] inst_len;
    } item_t;

    // Period table, indices past the last entry return PER_MIN
    function automatic logic [9:0] per_tab(input logic [6:0] idx);
        logic [9:0] p;
        case (idx)
            7'd0:  p = 10'd1019;
            7'd1:  p = 10'd962;
            7'd2:  p = 10'd908;
            7'd3:  p = 10'd857;
            7'd4:  p = 10'd809;
            7'd5:  p = 10'd763;
            7'd6:  p = 10'd720;
            7'd7:  p = 10'd680;
            7'd8:  p = 10'd642;
            7'd9:  p = 10'd606;
            7'd10: p = 10'd572;
            7'd11: p = 10'd540;
            7'd12: p = 10'd509;
            7'd13: p = 10'd481;
            7'd14: p = 10'd454;
            7'd15: p = 10'd428;
            7'd16: p = 10'd404;
            7'd17: p = 10'd381;
            7'd18: p = 10'd360;
            7'd19: p = 10'd340;
            7'd20: p = 10'd321;
            7'd21: p = 10'd303;
            7'd22: p = 10'd286;
            7'd23: p = 10'd270;
            7'd24: p = 10'd254;
            7'd25: p = 10'd240;
            7'd26: p = 10'd227;
            7'd27: p = 10'd214;
            7'd28: p = 10'd202;
            7'd29: p = 10'd190;
            7'd30: p = 10'd180;
            7'd31: p = 10'd170;
            7'd32: p = 10'd160;
            7'd33: p = 10'd151;
            7'd34: p = 10'd143;
            default: p = PER_MIN;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/tvfe_front.sv =====
// Front end: classify an incoming item and look up its note period.
module tvfe_front #(
    parameter int VOICES = tvfe_pkg::VOICES_DEF
) (
    input  logic                s_command,
    input  logic [1:0]          s_voice_select,
    input  logic [7:0]          s_period_code,
    input  logic [7:0]          s_speed_byte,
    input  logic [7:0]          s_arpeggio_byte,
    input  logic [7:0]          s_vibrato_byte,
    input  logic [7:0]          s_volume_byte,
    input  logic [7:0]          s_porta_byte,
    input  logic                s_inst_present,
    input  logic [1:0]          s_inst_flags,
    input  logic [15:0]         s_inst_half_length,
    output tvfe_pkg::item_t     item
);
    logic [7:0] idx_raw;

    // Saturate the note index and decode flag bits
    always_comb begin
        idx_raw            = s_period_code - 8'd1;
        item.cmd           = s_command;
        item.voice         = s_voice_select;
        item.in_range      = (32'(s_voice_select) < VOICES);
        item.has_note      = (s_period_code != 8'd0);
        item.note_idx      = (idx_raw > 8'(tvfe_pkg::TAB_LAST)) ? tvfe_pkg::TAB_LAST
                                                                 : idx_raw[5:0];
        item.note_per      = tvfe_pkg::per_tab({1'b0, item.note_idx});
        item.porta_tgt     = s_speed_byte[6];
        item.vol_preset    = s_speed_byte[7];
        item.speed         = s_speed_byte[3:0];
        item.arp           = s_arpeggio_byte;
        item.vib           = s_vibrato_byte;
        item.vol           = s_volume_byte;
        item.porta         = s_porta_byte;
        item.inst_present  = s_inst_present;
        item.inst_flags    = s_inst_flags;
        item.inst_len      = s_inst_half_length;
    end
endmodule

// ===== sv/tvfe_queue.sv =====
// Two-entry queue between the front and the back.
module tvfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tvfe_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tvfe_pkg::item_t pop_item
);
    tvfe_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold item storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

// ===== sv/tvfe_back.sv =====
// Back end: per-voice effect state, one row or frame update per item, result register.
module tvfe_back #(
    parameter int VOICES = tvfe_pkg::VOICES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  tvfe_pkg::item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [9:0]      m_period_out,
    output logic [9:0]      m_volume_out,
    output logic            m_start_sample,
    output logic            m_mute_voice,
    output logic [15:0]     m_play_words,
    output logic            m_loop_enable,
    output logic            m_am_wave,
    output logic [3:0]      m_row_speed
);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic [9:0]         slot_a_reg [VOICES];
    logic [9:0]         slot_b_reg [VOICES];
    logic [9:0]         slot_c_reg [VOICES];
    logic [5:0]         base_reg   [VOICES];
    logic signed [10:0] soff_reg   [VOICES];
    logic signed [8:0]  sstep_reg  [VOICES];
    logic [9:0]         slim_reg   [VOICES];
    logic signed [11:0] voff_reg   [VOICES];
    logic signed [4:0]  vstep_reg  [VOICES];
    logic [3:0]         vcnt_reg   [VOICES];
    logic [3:0]         vrel_reg   [VOICES];
    logic [7:0]         lvl_reg    [VOICES];
    logic signed [7:0]  lstep_reg  [VOICES];
    logic [7:0]         lpre_reg   [VOICES];
    logic [3:0]         speed_reg, speed_next;

    logic [VW-1:0]      v;
    logic [9:0]         a, b, c, t0, pb;
    logic [5:0]         base;
    logic signed [10:0] soff;
    logic signed [11:0] soff_sum;
    logic signed [8:0]  sstep;
    logic [9:0]         slim;
    logic signed [11:0] voff;
    logic signed [4:0]  vstep;
    logic [3:0]         vcnt, vrel;
    logic [7:0]         lvl, lpre;
    logic signed [7:0]  lstep;
    logic signed [9:0]  lvl_sum;
    logic signed [13:0] per;
    logic               start, mute, loop, am;
    logic [15:0]        words;
    logic [9:0]         per_out, vol_out;
    logic               write_en;

    logic               m_valid_reg;
    logic [9:0]         per_reg, vol_reg;
    logic               start_reg, mute_reg, loop_reg, am_reg;
    logic [15:0]        words_reg;
    logic [3:0]         rspeed_reg;

    assign v        = VW'(q_item.voice);
    assign q_pop    = q_valid && (!m_valid_reg || m_ready);
    assign write_en = q_pop && q_item.in_range;

    // Apply the row note for a row item, then one frame for the addressed voice
    always_comb begin
        a = slot_a_reg[v];  b = slot_b_reg[v];  c = slot_c_reg[v];
        base = base_reg[v]; soff = soff_reg[v]; sstep = sstep_reg[v];
        slim = slim_reg[v]; voff = voff_reg[v]; vstep = vstep_reg[v];
        vcnt = vcnt_reg[v]; vrel = vrel_reg[v]; lvl = lvl_reg[v];
        lstep = lstep_reg[v]; lpre = lpre_reg[v];
        speed_next = speed_reg;
        start = 1'b0; mute = 1'b0; loop = 1'b0; am = 1'b0; words = 16'd0;
        pb = 10'd0; t0 = 10'd0;

        if (q_item.cmd == tvfe_pkg::CMD_ROW) begin
            // Note: set limit for a portamento target, else restart
            if (q_item.has_note) begin
                if (q_item.porta_tgt) begin
                    slim = q_item.note_per;
                end else begin
                    start = 1'b1;
                    base  = q_item.note_idx;
                    a = q_item.note_per; b = q_item.note_per; c = q_item.note_per;
                    soff  = 11'sd0;
                    if (!q_item.inst_present) begin
                        mute = 1'b1;
                    end else begin
                        words = q_item.inst_flags[1] ? tvfe_pkg::AM_WORDS : q_item.inst_len;
                        loop  = q_item.inst_flags[0];
                        am    = q_item.inst_flags[1];
                        lvl   = lpre;
                    end
                end
            end
            if (q_item.speed != 4'd0) begin
                speed_next = q_item.speed;
            end

            // Arpeggio ring
            pb = tvfe_pkg::per_tab({1'b0, base});
            if (q_item.arp == tvfe_pkg::BYTE_STOP) begin
                a = pb; b = pb; c = pb;
            end else if (q_item.arp != 8'd0) begin
                c = tvfe_pkg::per_tab(7'(base) + 7'(q_item.arp[3:0]));
                b = tvfe_pkg::per_tab(7'(base) + 7'(q_item.arp[7:4]));
                a = pb;
            end

            // Vibrato
            if (q_item.vib != 8'd0) begin
                voff = 12'sd0;
                if (q_item.vib == tvfe_pkg::BYTE_STOP) begin
                    vstep = 5'sd0;
                    vcnt  = 4'd0;
                end else begin
                    vstep = $signed({1'b0, q_item.vib[3:0]});
                    vrel  = q_item.vib[7:4];
                    vcnt  = {1'b0, q_item.vib[7:5]};
                end
            end

            // Volume preset or slide
            if (q_item.vol == 8'd0) begin
                if (q_item.vol_preset) begin
                    lvl = 8'd0; lpre = 8'd0; lstep = 8'sd0;
                end
            end else if (q_item.vol == tvfe_pkg::BYTE_STOP) begin
                lstep = 8'sd0;
            end else if (q_item.vol_preset) begin
                lvl = q_item.vol; lpre = q_item.vol; lstep = 8'sd0;
            end else begin
                lstep = q_item.vol[7] ? -$signed({1'b0, q_item.vol[6:0]})
                                      :  $signed({1'b0, q_item.vol[6:0]});
            end

            // Portamento direction and limit
            if (q_item.porta != 8'd0) begin
                soff = 11'sd0;
                if (q_item.porta == tvfe_pkg::BYTE_STOP) begin
                    sstep = 9'sd0;
                end else if (q_item.porta_tgt) begin
                    sstep = (slim <= a) ? -$signed({1'b0, q_item.porta})
                                        :  $signed({1'b0, q_item.porta});
                end else if (!q_item.porta[7]) begin
                    sstep = -$signed({2'b0, q_item.porta[6:0]});
                    slim  = tvfe_pkg::PER_MIN;
                end else begin
                    sstep = $signed({2'b0, q_item.porta[6:0]});
                    slim  = tvfe_pkg::PER_MAX;
                end
            end
        end

        // Skip zero ring heads, at most twice
        if (a == 10'd0) begin
            t0 = a; a = b; b = c; c = t0;
            if (a == 10'd0) begin
                t0 = a; a = b; b = c; c = t0;
            end
        end

        // Period: portamento clamp at limit, vibrato, range clamp
        per = $signed({4'b0, a}) + 14'(soff);
        if (soff < 0) begin
            if (per < $signed({4'b0, slim})) per = $signed({4'b0, slim});
        end else if (soff != 0) begin
            if (per > $signed({4'b0, slim})) per = $signed({4'b0, slim});
        end
        per = per + 14'(voff);
        if (per < $signed({4'b0, tvfe_pkg::PER_MIN})) begin
            per_out = tvfe_pkg::PER_MIN;
        end else if (per > $signed({4'b0, tvfe_pkg::PER_MAX})) begin
            per_out = tvfe_pkg::PER_MAX;
        end else begin
            per_out = per[9:0];
        end
        t0 = a; a = b; b = c; c = t0;

        // Advance portamento offset
        soff_sum = 12'(soff) + 12'(sstep);
        if (soff_sum < -$signed({2'b0, tvfe_pkg::PER_MAX})) begin
            soff = -$signed({1'b0, tvfe_pkg::PER_MAX});
        end else if (soff_sum > $signed({2'b0, tvfe_pkg::PER_MAX})) begin
            soff = $signed({1'b0, tvfe_pkg::PER_MAX});
        end else begin
            soff = soff_sum[10:0];
        end

        // Advance vibrato
        if (vcnt != 4'd0) begin
            voff = voff + 12'(vstep);
            vcnt = vcnt - 4'd1;
            if (vcnt == 4'd0) begin
                vstep = -vstep;
                vcnt  = vrel;
            end
        end

        // Volume out, then slide clamped to 0..64
        vol_out = {lvl, 2'b00};
        lvl_sum = $signed({2'b0, lvl}) + 10'(lstep);
        if (lvl_sum < 0) begin
            lvl = 8'd0;
        end else if (lvl_sum > $signed({2'b0, tvfe_pkg::LEVEL_MAX})) begin
            lvl = tvfe_pkg::LEVEL_MAX;
        end else begin
            lvl = lvl_sum[7:0];
        end
    end

    // Write back voice state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < VOICES; i++) begin
                slot_a_reg[i] <= tvfe_pkg::PER_MAX;
                slot_b_reg[i] <= 10'd0;
                slot_c_reg[i] <= 10'd0;
                base_reg[i]   <= 6'd0;
                soff_reg[i]   <= 11'sd0;
                sstep_reg[i]  <= 9'sd0;
                slim_reg[i]   <= 10'd0;
                voff_reg[i]   <= 12'sd0;
                vstep_reg[i]  <= 5'sd0;
                vcnt_reg[i]   <= 4'd0;
                vrel_reg[i]   <= 4'd0;
                lvl_reg[i]    <= 8'd0;
                lstep_reg[i]  <= 8'sd0;
                lpre_reg[i]   <= tvfe_pkg::LEVEL_MAX;
            end
            speed_reg <= tvfe_pkg::SPEED_RST;
        end else if (write_en) begin
            slot_a_reg[v] <= a;     slot_b_reg[v] <= b;     slot_c_reg[v] <= c;
            base_reg[v]   <= base;  soff_reg[v]   <= soff;  sstep_reg[v]  <= sstep;
            slim_reg[v]   <= slim;  voff_reg[v]   <= voff;  vstep_reg[v]  <= vstep;
            vcnt_reg[v]   <= vcnt;  vrel_reg[v]   <= vrel;  lvl_reg[v]    <= lvl;
            lstep_reg[v]  <= lstep; lpre_reg[v]   <= lpre;
            speed_reg     <= speed_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            per_reg    <= q_item.in_range ? per_out : 10'd0;
            vol_reg    <= q_item.in_range ? vol_out : 10'd0;
            start_reg  <= q_item.in_range && start;
            mute_reg   <= q_item.in_range && mute;
            words_reg  <= q_item.in_range ? words : 16'd0;
            loop_reg   <= q_item.in_range && loop;
            am_reg     <= q_item.in_range && am;
            rspeed_reg <= q_item.in_range ? speed_next : speed_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_period_out   = per_reg;
    assign m_volume_out   = vol_reg;
    assign m_start_sample = start_reg;
    assign m_mute_voice   = mute_reg;
    assign m_play_words   = words_reg;
    assign m_loop_enable  = loop_reg;
    assign m_am_wave      = am_reg;
    assign m_row_speed    = rspeed_reg;
endmodule

// ===== sv/tracker_voice_effect_engine_top.sv =====
// Top level of the tracker voice effect engine.
// Input channel (s_*): one item per voice per row or tick. s_command selects a
// tick (frame only) or a row (decode the note cell, then a frame). All other
// s_ fields are the note cell and instrument data of the addressed voice.
// Result channel (m_*): exactly one result per accepted item, in order: the
// clamped period, volume times four, restart/mute flags, sample words, loop
// and AM flags, and the row speed after the item.
// Throughput: one item per cycle while the receiver takes results; the whole
// row/frame update of a voice is done combinationally in the back end, so items
// for the same voice may follow back to back.
// When nothing stalls, an accepted item is written into a queue entry, then
// moves to the result register, where it is held valid until the receiver
// takes it.
// When the receiver stalls, the result register holds, the queue fills and
// s_ready drops once both entries are taken.
// Reset (aresetn low, synchronous) returns every voice to its start state and
// the row speed to six; no result is pending afterward.
module tracker_voice_effect_engine_top #(
    parameter int VOICES = tvfe_pkg::VOICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [1:0]  s_voice_select,
    input  logic [7:0]  s_period_code,
    input  logic [7:0]  s_speed_byte,
    input  logic [7:0]  s_arpeggio_byte,
    input  logic [7:0]  s_vibrato_byte,
    input  logic [7:0]  s_volume_byte,
    input  logic [7:0]  s_porta_byte,
    input  logic        s_inst_present,
    input  logic [1:0]  s_inst_flags,
    input  logic [15:0] s_inst_half_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_period_out,
    output logic [9:0]  m_volume_out,
    output logic        m_start_sample,
    output logic        m_mute_voice,
    output logic [15:0] m_play_words,
    output logic        m_loop_enable,
    output logic        m_am_wave,
    output logic [3:0]  m_row_speed
);
    tvfe_pkg::item_t in_item, q_item;
    logic            q_full, q_valid, q_pop;

    assign s_ready = !q_full;

    tvfe_front #(.VOICES(VOICES)) u_front (
        .s_command          (s_command),
        .s_voice_select     (s_voice_select),
        .s_period_code      (s_period_code),
        .s_speed_byte       (s_speed_byte),
        .s_arpeggio_byte    (s_arpeggio_byte),
        .s_vibrato_byte     (s_vibrato_byte),
        .s_volume_byte      (s_volume_byte),
        .s_porta_byte       (s_porta_byte),
        .s_inst_present     (s_inst_present),
        .s_inst_flags       (s_inst_flags),
        .s_inst_half_length (s_inst_half_length),
        .item               (in_item)
    );

    tvfe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (q_item)
    );

    tvfe_back #(.VOICES(VOICES)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_period_out   (m_period_out),
        .m_volume_out   (m_volume_out),
        .m_start_sample (m_start_sample),
        .m_mute_voice   (m_mute_voice),
        .m_play_words   (m_play_words),
        .m_loop_enable  (m_loop_enable),
        .m_am_wave      (m_am_wave),
        .m_row_speed    (m_row_speed)
    );
endmodule

// ===== sv/tvfe_checker.sv =====
// Port checker for the tracker voice effect engine, bound to the top level.
module tvfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [9:0]  m_period_out,
    input logic [9:0]  m_volume_out,
    input logic        m_start_sample,
    input logic        m_mute_voice,
    input logic [15:0] m_play_words
);
    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_period_out) && $stable(m_volume_out))
        else $error("result changed while stalled");

    // A muted voice is a restart with no sample words
    a_mute: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mute_voice |-> m_start_sample && (m_play_words == 16'd0))
        else $error("mute without restart or with words");

    // Volume is a level times four
    a_vol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_volume_out[1:0] == 2'b00))
        else $error("volume not a multiple of four");

    // No sample words without a restart
    a_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_start_sample |-> (m_play_words == 16'd0))
        else $error("sample words without restart");
endmodule

bind tracker_voice_effect_engine_top tvfe_checker u_tvfe_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_period_out   (m_period_out),
    .m_volume_out   (m_volume_out),
    .m_start_sample (m_start_sample),
    .m_mute_voice   (m_mute_voice),
    .m_play_words   (m_play_words)
);
